// File: src/rwd_pkg.sv
`timescale 1ns / 1ps
// Shared widths, command codes and the controller/datapath command bundle
// for the reaction wheel drive. No dependencies.
package rwd_pkg;

	// Signed Q16.16 data path.
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int OP_W      = 2;
	localparam int MODE_W    = 2;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SH_W      = PROD_W - FRAC_BITS;

	// Command opcodes carried by an input beat.
	typedef enum logic [OP_W-1:0] {
		OP_TICK       = 2'd0,
		OP_SET_SPEED  = 2'd1,
		OP_SET_TORQUE = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	// Drive mode.
	typedef enum logic [MODE_W-1:0] {
		MODE_NONE = 2'd0,
		MODE_VEL  = 2'd1,
		MODE_TRQ  = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED     = 3'd0,
		REG_MAX_TORQUE    = 3'd1,
		REG_KP_GAIN       = 3'd2,
		REG_INV_INERTIA   = 3'd3,
		REG_TIME_STEP     = 3'd4,
		REG_SAMPLE_PERIOD = 3'd5,
		REG_SLEW_STEP     = 3'd6
	} cfg_reg_t;

	// Operand pairs of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_PWR_SPEED  = 3'd0,
		MUL_PWR_TORQUE = 3'd1,
		MUL_ERR_KP     = 3'd2,
		MUL_TORQ_INV   = 3'd3,
		MUL_ACC_TS     = 3'd4
	} mul_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic     load;        // latch the clamped power of an accepted beat
		logic     mul_en;      // register a product
		mul_sel_t mul_sel;
		logic     set_speed;   // write speed target and mode
		logic     set_torque;  // write torque target and mode
		logic     clear;       // clear targets, torque and speed
		logic     loop;        // advance the sample timer, form the speed error
		logic     load_tgt;    // write the loop's torque target
		logic     slew;        // slew the applied torque
		logic     load_acc;    // latch the saturated acceleration
		logic     integrate;   // update the speed
		logic     load_out;    // fill the result register
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic sample;          // speed loop sample is due on this tick
	} dp_stat_t;

endpackage

// File: src/rwd_cmd_if.sv
`timescale 1ns / 1ps
// Command channel of the reaction wheel drive: valid/ready plus payload.
// Depends on rwd_pkg.
interface rwd_cmd_if;
	import rwd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [DATA_W-1:0] power;

	modport source (output valid, output opcode, output power, input ready);
	modport sink   (input valid, input opcode, input power, output ready);
endinterface

// File: src/rwd_res_if.sv
`timescale 1ns / 1ps
// Result channel of the reaction wheel drive: valid/ready plus payload.
// Depends on rwd_pkg.
interface rwd_res_if;
	import rwd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] wheel_speed;
	logic signed [DATA_W-1:0] wheel_torque;
	logic [MODE_W-1:0]        active_mode;

	modport source (output valid, output wheel_speed, output wheel_torque,
		output active_mode, input ready);
	modport sink   (input valid, input wheel_speed, input wheel_torque,
		input active_mode, output ready);
endinterface

// File: src/reaction_wheel_drive_step.sv
`timescale 1ns / 1ps
// Top level of the reaction wheel drive: controller, datapath and channels.
// Depends on rwd_pkg, rwd_cmd_if, rwd_res_if, rwd_ctrl and rwd_datapath.
//
//  Channel  Direction  Payload                                   Beat taken when
//  cmd      in         opcode[1:0], power[31:0] signed           valid && ready
//  res      out        wheel_speed, wheel_torque, active_mode    valid && ready
//  cfg      in         cfg_idx[2:0], cfg_data[30:0]              cfg_we
//
// A tick slews the torque and integrates the speed, first updating the torque target
// when the speed loop samples; set speed or set torque scales the power; a clear zeroes
// targets, torque and speed. Ticks use the single 32x32 multiplier up to three times.
// arst_n returns the registers to their defaults and clears the drive state at once.
// The result register lets a new command be accepted while the last result
// waits; a held result stalls the next command only at its final step.
module reaction_wheel_drive_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rwd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rwd_pkg::CFG_W-1:0]     cfg_data,
	rwd_cmd_if.sink                       cmd,
	rwd_res_if.source                     res
);
	import rwd_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer.
	rwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_opcode (cmd.opcode),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// Arithmetic and state.
	rwd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_power   (cmd.power),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.out_speed  (res.wheel_speed),
		.out_torque (res.wheel_torque),
		.out_mode   (res.active_mode)
	);

endmodule

// File: src/rwd_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the reaction wheel drive and the result
// valid flag. Depends on rwd_pkg.
module rwd_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [rwd_pkg::OP_W-1:0] in_opcode,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  rwd_pkg::dp_stat_t       stat,
	output rwd_pkg::dp_cmd_t        cmd
);
	import rwd_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_SET_MUL = 13'b0000000000010,
		S_SET_WR  = 13'b0000000000100,
		S_CLEAR   = 13'b0000000001000,
		S_LOOP    = 13'b0000000010000,
		S_ERR_MUL = 13'b0000000100000,
		S_TGT     = 13'b0000001000000,
		S_SLEW    = 13'b0000010000000,
		S_ACC_MUL = 13'b0000100000000,
		S_ACC     = 13'b0001000000000,
		S_DV_MUL  = 13'b0010000000000,
		S_SPEED   = 13'b0100000000000,
		S_OUT     = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   set_speed_q, set_speed_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		set_speed_d = set_speed_q;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (op_t'(in_opcode))
						OP_TICK:       state_d = S_LOOP;
						OP_SET_SPEED: begin
							set_speed_d = 1'b1;
							state_d     = S_SET_MUL;
						end
						OP_SET_TORQUE: begin
							set_speed_d = 1'b0;
							state_d     = S_SET_MUL;
						end
						OP_CLEAR:      state_d = S_CLEAR;
					endcase
				end
			end
			S_SET_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = set_speed_q ? MUL_PWR_SPEED : MUL_PWR_TORQUE;
				state_d     = S_SET_WR;
			end
			S_SET_WR: begin
				cmd.set_speed  = set_speed_q;
				cmd.set_torque = !set_speed_q;
				state_d        = S_OUT;
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = S_OUT;
			end
			S_LOOP: begin
				cmd.loop = 1'b1;
				state_d  = stat.sample ? S_ERR_MUL : S_SLEW;
			end
			S_ERR_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_KP;
				state_d     = S_TGT;
			end
			S_TGT: begin
				cmd.load_tgt = 1'b1;
				state_d      = S_SLEW;
			end
			S_SLEW: begin
				cmd.slew = 1'b1;
				state_d  = S_ACC_MUL;
			end
			S_ACC_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TORQ_INV;
				state_d     = S_ACC;
			end
			S_ACC: begin
				cmd.load_acc = 1'b1;
				state_d      = S_DV_MUL;
			end
			S_DV_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ACC_TS;
				state_d     = S_SPEED;
			end
			S_SPEED: begin
				cmd.integrate = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				// Wait only while the previous result is still held.
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			set_speed_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			set_speed_q <= set_speed_d;
		end
	end

	// Result register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/rwd_datapath.sv
`timescale 1ns / 1ps
// Datapath of the reaction wheel drive: configuration registers, drive
// state, one shared signed multiplier and the result register. Depends on rwd_pkg.
module rwd_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rwd_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rwd_pkg::CFG_W-1:0]         cfg_data,
	input  logic signed [rwd_pkg::DATA_W-1:0] in_power,
	input  rwd_pkg::dp_cmd_t                  cmd,
	output rwd_pkg::dp_stat_t                 stat,
	output logic signed [rwd_pkg::DATA_W-1:0] out_speed,
	output logic signed [rwd_pkg::DATA_W-1:0] out_torque,
	output logic [rwd_pkg::MODE_W-1:0]        out_mode
);
	import rwd_pkg::*;

	localparam logic [CFG_W-1:0] RST_MAX_SPEED   = CFG_W'(6553600);
	localparam logic [CFG_W-1:0] RST_MAX_TORQUE  = CFG_W'(65536);
	localparam logic [CFG_W-1:0] RST_KP_GAIN     = CFG_W'(2130);
	localparam logic [CFG_W-1:0] RST_INV_INERTIA = CFG_W'(65536);
	localparam logic [CFG_W-1:0] RST_TIME_STEP   = CFG_W'(655);
	localparam logic [CFG_W-1:0] RST_PERIOD      = CFG_W'(655);
	localparam logic [CFG_W-1:0] RST_SLEW_STEP   = CFG_W'(655);

	localparam logic signed [DATA_W-1:0] ONE_Q     = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] NEG_ONE_Q = -ONE_Q;
	localparam logic signed [DATA_W-1:0] DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

	// Saturate a shifted product or wide sum to the signed data range.
	function automatic logic signed [DATA_W-1:0] sat_sh(input logic signed [SH_W-1:0] x);
		logic fits;
		fits = (x[SH_W-1:DATA_W-1] == {(SH_W-DATA_W+1){x[SH_W-1]}});
		if (fits) return x[DATA_W-1:0];
		else if (x[SH_W-1]) return DATA_MIN;
		else return DATA_MAX;
	endfunction

	// Clamp to plus or minus an unsigned limit.
	function automatic logic signed [DATA_W-1:0] clamp_sh(input logic signed [SH_W-1:0] x,
		input logic [CFG_W-1:0] lim);
		logic signed [SH_W-1:0] pos;
		logic signed [SH_W-1:0] neg;
		pos = $signed({{(SH_W-CFG_W){1'b0}}, lim});
		neg = -pos;
		if (x > pos) return pos[DATA_W-1:0];
		else if (x < neg) return neg[DATA_W-1:0];
		else return x[DATA_W-1:0];
	endfunction

	// Configuration registers.
	logic [CFG_W-1:0] max_speed_q, max_torque_q, kp_gain_q, inv_inertia_q;
	logic [CFG_W-1:0] time_step_q, period_q, slew_step_q;

	// Drive state.
	mode_t                    mode_q;
	logic signed [DATA_W-1:0] tgt_speed_q, tgt_torque_q, torque_q, speed_q;
	logic [DATA_W-1:0]        elapsed_q;

	// Multiplier operand and product.
	logic signed [DATA_W-1:0] work_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SH_W-1:0]   prod_sh;

	// Result register.
	logic signed [DATA_W-1:0] res_speed_q, res_torque_q;
	logic [MODE_W-1:0]        res_mode_q;

	logic signed [DATA_W-1:0] power_clamped;
	logic signed [DATA_W-1:0] mul_a;
	logic [CFG_W-1:0]         mul_b;
	logic [DATA_W:0]          el_sum;
	logic [DATA_W-1:0]        el_next;
	logic signed [DATA_W-1:0] err_sat;
	logic signed [SH_W-1:0]   slew_amt, slew_sum, spd_sum;
	logic signed [DATA_W-1:0] torque_next, dv_sat, speed_next;

	assign prod_sh = $signed(prod_q[PROD_W-1:FRAC_BITS]);

	// Configuration writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= RST_MAX_SPEED;
			max_torque_q  <= RST_MAX_TORQUE;
			kp_gain_q     <= RST_KP_GAIN;
			inv_inertia_q <= RST_INV_INERTIA;
			time_step_q   <= RST_TIME_STEP;
			period_q      <= RST_PERIOD;
			slew_step_q   <= RST_SLEW_STEP;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_SPEED:     max_speed_q   <= cfg_data;
				REG_MAX_TORQUE:    max_torque_q  <= cfg_data;
				REG_KP_GAIN:       kp_gain_q     <= cfg_data;
				REG_INV_INERTIA:   inv_inertia_q <= cfg_data;
				REG_TIME_STEP:     time_step_q   <= cfg_data;
				REG_SAMPLE_PERIOD: period_q      <= cfg_data;
				REG_SLEW_STEP:     slew_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Power saturated to plus or minus one.
	always_comb begin
		if (in_power > ONE_Q) power_clamped = ONE_Q;
		else if (in_power < NEG_ONE_Q) power_clamped = NEG_ONE_Q;
		else power_clamped = in_power;
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = work_q;
		mul_b = kp_gain_q;
		unique case (cmd.mul_sel)
			MUL_PWR_SPEED:  mul_b = max_speed_q;
			MUL_PWR_TORQUE: mul_b = max_torque_q;
			MUL_ERR_KP:     mul_b = kp_gain_q;
			MUL_TORQ_INV: begin
				mul_a = torque_q;
				mul_b = inv_inertia_q;
			end
			MUL_ACC_TS:     mul_b = time_step_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
		end
	end

	// Sample timer saturates at all ones; the sample is due once it reaches the period.
	assign el_sum      = {1'b0, elapsed_q} + {2'b00, time_step_q};
	assign el_next     = el_sum[DATA_W] ? {DATA_W{1'b1}} : el_sum[DATA_W-1:0];
	assign stat.sample = (mode_q == MODE_VEL) && (el_next >= {1'b0, period_q});

	// Speed error, saturated.
	assign err_sat = sat_sh(SH_W'(tgt_speed_q) - SH_W'(speed_q));

	// Torque moves a whole step toward its target, then is clamped.
	always_comb begin
		slew_amt = SH_W'($signed({1'b0, slew_step_q}));
		if (tgt_torque_q > torque_q) slew_sum = SH_W'(torque_q) + slew_amt;
		else if (tgt_torque_q < torque_q) slew_sum = SH_W'(torque_q) - slew_amt;
		else slew_sum = SH_W'(torque_q);
		torque_next = clamp_sh(slew_sum, max_torque_q);
	end

	// Speed integration.
	assign dv_sat     = sat_sh(prod_sh);
	assign spd_sum    = SH_W'(speed_q) + SH_W'(dv_sat);
	assign speed_next = clamp_sh(spd_sum, max_speed_q);

	// Multiplier operand register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= power_clamped;
		end else if (cmd.loop) begin
			work_q <= err_sat;
		end else if (cmd.load_acc) begin
			work_q <= sat_sh(prod_sh);
		end
	end

	// Drive state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NONE;
			tgt_speed_q  <= '0;
			tgt_torque_q <= '0;
			torque_q     <= '0;
			speed_q      <= '0;
			elapsed_q    <= '0;
		end else begin
			if (cmd.set_speed) begin
				mode_q      <= MODE_VEL;
				tgt_speed_q <= prod_sh[DATA_W-1:0];
			end
			if (cmd.set_torque) begin
				mode_q       <= MODE_TRQ;
				tgt_torque_q <= prod_sh[DATA_W-1:0];
			end
			if (cmd.loop && mode_q == MODE_VEL) begin
				elapsed_q <= stat.sample ? '0 : el_next;
			end
			if (cmd.load_tgt) begin
				tgt_torque_q <= clamp_sh(prod_sh, max_torque_q);
			end
			if (cmd.slew && mode_q != MODE_NONE) begin
				torque_q <= torque_next;
			end
			if (cmd.integrate) begin
				speed_q <= speed_next;
			end
			if (cmd.clear) begin
				tgt_speed_q  <= '0;
				tgt_torque_q <= '0;
				torque_q     <= '0;
				speed_q      <= '0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_speed_q  <= speed_q;
			res_torque_q <= torque_q;
			res_mode_q   <= mode_q;
		end
	end

	assign out_speed  = res_speed_q;
	assign out_torque = res_torque_q;
	assign out_mode   = res_mode_q;

endmodule

// File: src/rwd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the reaction wheel drive and the bind that attaches
// them to the top level. Depends on rwd_pkg and reaction_wheel_drive_step.
module rwd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic [rwd_pkg::OP_W-1:0]          cmd_opcode,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic signed [rwd_pkg::DATA_W-1:0] res_speed,
	input logic signed [rwd_pkg::DATA_W-1:0] res_torque,
	input logic [rwd_pkg::MODE_W-1:0]        res_mode
);
	import rwd_pkg::*;

	logic            in_beat;
	logic            out_beat;
	logic [1:0]      pending_q;
	logic [OP_W-1:0] last_op_q;

	assign in_beat  = cmd_valid && cmd_ready;
	assign out_beat = res_valid && res_ready;

	// Commands accepted whose result beat has not yet gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			last_op_q <= OP_TICK;
		end else begin
			if (in_beat && !out_beat) pending_q <= pending_q + 2'd1;
			else if (out_beat && !in_beat) pending_q <= pending_q - 2'd1;
			if (in_beat) last_op_q <= cmd_opcode;
		end
	end

	// A stalled result beat holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_speed)
			&& $stable(res_torque) && $stable(res_mode))
		else $error("result beat changed while stalled");

	// No result beat without a command behind it.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pending_q != 2'd0)
		else $error("result beat without a command");

	// Commands run one at a time; at most one earlier result may still wait.
	a_one_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> pending_q <= 2'd1)
		else $error("command accepted with two results outstanding");

	// The result of a clear shows a stopped wheel with no torque.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && pending_q == 2'd1 && last_op_q == OP_CLEAR
			|-> res_speed == '0 && res_torque == '0)
		else $error("clear did not zero speed and torque");

	// A mode command shows its own mode in its result.
	a_mode_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && pending_q == 2'd1
			&& (last_op_q == OP_SET_SPEED || last_op_q == OP_SET_TORQUE)
			|-> (last_op_q == OP_SET_SPEED && res_mode == MODE_VEL)
			|| (last_op_q == OP_SET_TORQUE && res_mode == MODE_TRQ))
		else $error("mode command reported the wrong mode");

endmodule

bind reaction_wheel_drive_step rwd_checker u_rwd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_opcode (cmd.opcode),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_speed  (res.wheel_speed),
	.res_torque (res.wheel_torque),
	.res_mode   (res.active_mode)
);

// File: tb/sv/reaction_wheel_drive_step_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for reaction_wheel_drive_step: drives command beats and register
// writes, predicts every result beat in a scoreboard class and compares it field by field.
// Depends on rwd_pkg, rwd_cmd_if, rwd_res_if and the block itself.
module reaction_wheel_drive_step_tb;
	import rwd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_PHASE  = 2;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 60;
	localparam int TAIL_ITEMS  = 50;
	localparam int NUM_REGS    = 7;
	localparam int MAX_REPORTS = 10;

	// Unmapped register index; writes to it are dropped by the block.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [CFG_W-1:0]     CFG_MAX   = 31'h7FFF_FFFF;
	localparam logic [CFG_W-1:0]     CFG_RESET [NUM_REGS] = '{
		31'd6553600, 31'd65536, 31'd2130, 31'd65536, 31'd655, 31'd655, 31'd655
	};

	// Register settings used per phase.
	localparam int PROFILE_TOP   = 0;
	localparam int PROFILE_ZERO  = 1;
	localparam int PROFILE_RESET = 2;
	localparam int PROFILE_MIXED = 3;

	localparam longint Q_ONE    = 64'sd65536;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -WORD_MAX - 64'sd1;
	localparam longint TIMER_MAX = 64'sh0_FFFF_FFFF;

	typedef struct packed {
		logic signed [DATA_W-1:0] speed;
		logic signed [DATA_W-1:0] torque;
		logic [MODE_W-1:0]        mode;
	} reading_t;

	// Tracks the drive state, predicts each result beat and checks the block's output.
	class drive_scoreboard;
		logic [CFG_W-1:0] regs [NUM_REGS];
		mode_t            mode;
		longint           tgt_speed, tgt_torque, torque, speed, elapsed;
		reading_t         pending_readings[$];
		int               mismatches;

		function new();
			foreach (regs[i]) regs[i] = CFG_RESET[i];
			mode = MODE_NONE;
			tgt_speed = 0;
			tgt_torque = 0;
			torque = 0;
			speed = 0;
			elapsed = 0;
			mismatches = 0;
		endfunction

		function void write_reg(int idx, logic [CFG_W-1:0] val);
			if (idx < NUM_REGS) regs[idx] = val;
		endfunction

		function longint reg_val(cfg_reg_t r);
			return longint'(regs[r]);
		endfunction

		function longint sat_word(longint x);
			if (x > WORD_MAX) return WORD_MAX;
			if (x < WORD_MIN) return WORD_MIN;
			return x;
		endfunction

		function longint clamp_to(longint x, longint lim);
			if (x > lim) return lim;
			if (x < -lim) return -lim;
			return x;
		endfunction

		// Saturate the power to +-1.0, then scale by the limit with a floor shift.
		function longint scale_power(longint p, longint lim);
			if (p > Q_ONE) p = Q_ONE;
			if (p < -Q_ONE) p = -Q_ONE;
			return (p * lim) >>> FRAC_BITS;
		endfunction

		// The torque takes a whole step toward its target, possibly overshooting.
		function void slew_applied();
			longint t;
			t = torque;
			if (tgt_torque > torque) t = t + reg_val(REG_SLEW_STEP);
			else if (tgt_torque < torque) t = t - reg_val(REG_SLEW_STEP);
			torque = clamp_to(t, reg_val(REG_MAX_TORQUE));
		endfunction

		function void run_tick();
			longint err, accel, dv;
			// Speed loop: sample timer, then proportional update of the torque target.
			if (mode == MODE_VEL) begin
				elapsed = elapsed + reg_val(REG_TIME_STEP);
				if (elapsed > TIMER_MAX) elapsed = TIMER_MAX;
				if (elapsed >= reg_val(REG_SAMPLE_PERIOD)) begin
					err = sat_word(tgt_speed - speed);
					tgt_torque = clamp_to((err * reg_val(REG_KP_GAIN)) >>> FRAC_BITS,
						reg_val(REG_MAX_TORQUE));
					elapsed = 0;
				end
				slew_applied();
			end else if (mode == MODE_TRQ) begin
				slew_applied();
			end
			// Speed integrates in every mode.
			accel = sat_word((torque * reg_val(REG_INV_INERTIA)) >>> FRAC_BITS);
			dv = sat_word((accel * reg_val(REG_TIME_STEP)) >>> FRAC_BITS);
			speed = clamp_to(speed + dv, reg_val(REG_MAX_SPEED));
		endfunction

		function void note_command(logic [OP_W-1:0] opcode,
			logic signed [DATA_W-1:0] power);
			longint   p;
			reading_t r;
			p = longint'(power);
			case (op_t'(opcode))
				OP_TICK: begin
					run_tick();
				end
				OP_SET_SPEED: begin
					mode = MODE_VEL;
					tgt_speed = scale_power(p, reg_val(REG_MAX_SPEED));
				end
				OP_SET_TORQUE: begin
					mode = MODE_TRQ;
					tgt_torque = scale_power(p, reg_val(REG_MAX_TORQUE));
				end
				default: begin
					// Clear keeps the mode and the sample timer.
					tgt_speed = 0;
					tgt_torque = 0;
					torque = 0;
					speed = 0;
				end
			endcase
			r.speed = speed[DATA_W-1:0];
			r.torque = torque[DATA_W-1:0];
			r.mode = mode;
			pending_readings.push_back(r);
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result beat with nothing expected: %s%0d %s%0d %s%0d",
						$realtime, "speed ", got.speed, "torque ", got.torque,
						"mode ", got.mode);
				return;
			end
			want = pending_readings.pop_front();
			if (got.speed !== want.speed || got.torque !== want.torque ||
				got.mode !== want.mode) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result mismatch: expected %s%0d %s%0d %s%0d, got %s%0d %s%0d %s%0d",
						$realtime, "speed ", want.speed, "torque ", want.torque,
						"mode ", want.mode, "speed ", got.speed,
						"torque ", got.torque, "mode ", got.mode);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	rwd_cmd_if cmd_ch();
	rwd_res_if res_ch();

	drive_scoreboard sb;
	bit              idling = 1'b1;
	bit              hold_sink = 1'b0;
	int              quiet_cycles = 0;

	reaction_wheel_drive_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Beat monitors: results are checked before the same edge's command is noted.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_reading(reading_t'({res_ch.wheel_speed, res_ch.wheel_torque,
				res_ch.active_mode}));
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			sb.note_command(cmd_ch.opcode, cmd_ch.power);
	end

	// Watchdog on cycles without any beat on either channel.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_sink) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_sink = 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic op_t pick_opcode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return OP_TICK;
		if (r < 73) return OP_SET_SPEED;
		if (r < 91) return OP_SET_TORQUE;
		return OP_CLEAR;
	endfunction

	// In-range powers, with full-width noise, the saturation edges and values just past +-1.0.
	function automatic logic [DATA_W-1:0] pick_power();
		case ($urandom_range(0, 7))
			0, 1, 2: return DATA_W'($urandom_range(0, 131072)) - 32'd65536;
			3, 4:    return $urandom();
			5:       return 32'h7FFF_FFFF;
			6:       return 32'h8000_0000;
			default: return ($urandom_range(0, 1) != 0) ? 32'h0001_0001 : 32'hFFFE_FFFF;
		endcase
	endfunction

	function automatic int profile_of(int phase);
		case (phase)
			0:          return PROFILE_TOP;
			3:          return PROFILE_ZERO;
			PHASES - 1: return PROFILE_RESET;
			default:    return PROFILE_MIXED;
		endcase
	endfunction

	// One command beat: optional idle burst, then hold valid until the beat is taken.
	task automatic push_command(op_t op, logic [DATA_W-1:0] pwr);
		if (idling && $urandom_range(0, 7) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.power <= pwr;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted result has been checked.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_readings.size() != 0);
	endtask

	// Write all registers back to back, then the unmapped index.
	task automatic apply_settings(int profile);
		logic [CFG_W-1:0] v;
		int               i;
		for (i = 0; i < NUM_REGS; i++) begin
			case (profile)
				PROFILE_TOP:   v = CFG_MAX;
				PROFILE_ZERO:  v = '0;
				PROFILE_RESET: v = CFG_RESET[i];
				default: begin
					case ($urandom_range(0, 5))
						0:       v = '0;
						1:       v = CFG_MAX;
						2:       v = CFG_RESET[i];
						3, 4:    v = CFG_W'($urandom_range(0, 262144));
						default: v = CFG_W'($urandom());
					endcase
				end
			endcase
			cfg_we <= 1'b1;
			cfg_idx <= cfg_reg_t'(i);
			cfg_data <= v;
			@(posedge clk);
			sb.write_reg(i, v);
		end
		cfg_idx <= REG_SPARE;
		cfg_data <= CFG_W'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		int n;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_MAX_SPEED;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.opcode <= OP_TICK;
		cmd_ch.power <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings.
		push_command(OP_TICK, '0);                       // tick with no mode selected
		push_command(OP_SET_TORQUE, 32'h7FFF_FFFF);      // power saturates high
		repeat (3) push_command(OP_TICK, $urandom());
		push_command(OP_SET_TORQUE, 32'h8000_0000);      // power saturates low
		repeat (2) push_command(OP_TICK, $urandom());
		push_command(OP_SET_TORQUE, 32'h0000_0000);
		push_command(OP_TICK, '1);                       // slew steps exactly onto a zero target
		push_command(OP_SET_SPEED, 32'h0001_0000);       // exactly +1.0
		repeat (3) push_command(OP_TICK, '0);            // loop samples on every tick
		push_command(OP_SET_SPEED, 32'hFFFF_0000);       // exactly -1.0
		push_command(OP_TICK, '0);
		push_command(OP_SET_SPEED, 32'hFFFF_FFFF);       // tiny negative, floor rounding
		push_command(OP_TICK, '0);
		push_command(OP_CLEAR, 32'hFFFF_FFFF);           // clear keeps the mode
		push_command(OP_TICK, '0);
		push_command(OP_SET_SPEED, 32'h0001_0001);       // just above +1.0
		push_command(OP_TICK, '0);
		drain();

		// Random phases, each under its own register settings.
		for (phase = 0; phase < PHASES; phase++) begin
			apply_settings(profile_of(phase));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == HOLD_PHASE && n == 5)
					hold_sink = 1'b1;
				if (phase == PHASES - 1 && n == PHASE_ITEMS - TAIL_ITEMS)
					idling = 1'b0;
				push_command(pick_opcode(), pick_power());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: sim.f
src/rwd_pkg.sv
src/rwd_cmd_if.sv
src/rwd_res_if.sv
src/rwd_ctrl.sv
src/rwd_datapath.sv
src/reaction_wheel_drive_step.sv
src/rwd_checker.sv
tb/sv/reaction_wheel_drive_step_tb.sv
